[rtl/fcsr_pkg.sv]
package fcsr_pkg;

  localparam int unsigned SAMPLE_BITS  = 12;
  localparam int unsigned STORED_CHARS = 3;
  localparam int unsigned CFG_IDX_BITS = 4;
  localparam int unsigned TICK_BITS    = 16;

  function automatic int unsigned pow10(input int unsigned idx);
    int unsigned p;
    p = 1;
    for (int unsigned i = 0; i < 10; i++) begin
      if (i < idx) begin
        p = p * 10;
      end
    end
    return p;
  endfunction

  function automatic int unsigned calc_digits(input int unsigned bits);
    int unsigned m;
    int unsigned n;
    m = (1 << bits) - 1;
    n = 1;
    for (int unsigned i = 1; i < 10; i++) begin
      if (m >= pow10(i)) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  localparam int unsigned DIGITS     = calc_digits(SAMPLE_BITS);
  localparam int unsigned POW_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned POS_W      = $clog2(STORED_CHARS + 1);
  localparam int unsigned IDX_W      = $clog2(STORED_CHARS);
  localparam int unsigned PREFIX_LEN = 5;
  localparam int unsigned PRE_W      = $clog2(PREFIX_LEN);

  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_DELAY = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_RESEND      = CFG_IDX_BITS'(1);

  localparam logic [TICK_BITS-1:0] FIRST_DELAY_RESET = TICK_BITS'(1);
  localparam logic [TICK_BITS-1:0] RESEND_RESET      = TICK_BITS'(300);

  localparam logic [7:0] CH_START = 8'h21;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_PREFIX = 6'b000010,
    PH_DIGITS = 6'b000100,
    PH_HASH   = 6'b001000,
    PH_CR     = 6'b010000,
    PH_LF     = 6'b100000
  } emit_phase_t;

  typedef struct packed {
    logic [3:0]             digit;
    logic [SAMPLE_BITS-1:0] rest;
  } digit_step_t;

  function automatic logic [7:0] prefix_char(input logic [PRE_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      PRE_W'(0): c = CH_START;
      PRE_W'(1): c = CH_A;
      PRE_W'(2): c = CH_D;
      PRE_W'(3): c = CH_C;
      default:   c = CH_EQ;
    endcase
    return c;
  endfunction

  // Digit at the given power of ten, by comparing against its nine multiples.
  function automatic digit_step_t digit_step(input logic [SAMPLE_BITS-1:0] v,
                                             input logic [POW_W-1:0] idx);
    digit_step_t r;
    int unsigned vv;
    int unsigned p;
    int unsigned q;
    r  = '0;
    vv = 32'(v);
    for (int unsigned j = 0; j < DIGITS; j++) begin
      if (POW_W'(j) == idx) begin
        p = pow10(j);
        q = 0;
        for (int unsigned k = 1; k < 10; k++) begin
          if (vv >= k * p) begin
            q = k;
          end
        end
        r.digit = 4'(q);
        r.rest  = SAMPLE_BITS'(vv - q * p);
      end
    end
    return r;
  endfunction

  function automatic logic [POW_W-1:0] digit_top(input logic [SAMPLE_BITS-1:0] v);
    logic [POW_W-1:0] t;
    t = '0;
    for (int unsigned i = 1; i < DIGITS; i++) begin
      if (32'(v) >= pow10(i)) begin
        t = POW_W'(i);
      end
    end
    return t;
  endfunction

endpackage

[rtl/framed_command_sample_reporter.sv]
// Channel   Direction  Handshake            Payload
// in_       request    in_valid / in_stall  in_func, in_rx_byte, in_adc_sample
// out_      result     out_valid/ out_stall out_tx_byte, out_last
// cfg_      write      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// A request is registered when accepted and handled in the next cycle, so bytes and silent
// ticks go at one per cycle and the state changes in the cycle after acceptance. A
// reporting tick hands the report to the character sequencer, which puts out 9 to 12
// characters, one a cycle; the first is loaded from the prefix phase that the registered
// tick starts. A further reporting tick waits until the final character of the previous
// report is loaded into the output register. Reset is synchronous and active low;
// out_stall holds the output register and the sequencer, and cfg_ready is always high.
module framed_command_sample_reporter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic [7:0]                        in_rx_byte,
  input  logic [fcsr_pkg::SAMPLE_BITS-1:0]  in_adc_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_tx_byte,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcsr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [fcsr_pkg::TICK_BITS-1:0]    cfg_data
);

  logic                             in_valid_r, in_valid_nxt;
  logic                             in_func_r;
  logic [7:0]                       in_rx_byte_r;
  logic [fcsr_pkg::SAMPLE_BITS-1:0] in_sample_r;

  logic [fcsr_pkg::TICK_BITS-1:0]   first_delay_r, first_delay_nxt;
  logic [fcsr_pkg::TICK_BITS-1:0]   resend_r, resend_nxt;

  logic                             in_frame_r, in_frame_nxt;
  logic [7:0]                       chars_r [fcsr_pkg::STORED_CHARS];
  logic [7:0]                       chars_nxt [fcsr_pkg::STORED_CHARS];
  logic [fcsr_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                             active_r, active_nxt;
  logic [fcsr_pkg::TICK_BITS-1:0]   cd_r, cd_nxt;
  logic                             expired_r, expired_nxt;
  logic [fcsr_pkg::SAMPLE_BITS-1:0] held_r, held_nxt;
  logic                             held_valid_r, held_valid_nxt;

  fcsr_pkg::emit_phase_t            phase_r, phase_nxt;
  logic [fcsr_pkg::PRE_W-1:0]       pre_idx_r, pre_idx_nxt;
  logic [fcsr_pkg::POW_W-1:0]       pow_idx_r, pow_idx_nxt;
  logic [fcsr_pkg::SAMPLE_BITS-1:0] val_r, val_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [7:0]                       out_tx_byte_r, out_tx_byte_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             out_adv;
  logic                             emitter_free;
  logic                             proc_go;
  logic                             emit_req;
  logic                             emit_now;
  logic                             is_rst;
  logic                             is_ok;
  logic [fcsr_pkg::TICK_BITS-1:0]   tick_cd;
  logic                             tick_expired;
  logic [fcsr_pkg::SAMPLE_BITS-1:0] rep_val;
  fcsr_pkg::digit_step_t            step;

  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_tx_byte_r;
  assign out_last    = out_last_r;

  assign out_adv      = !out_valid_r || !out_stall;
  assign emitter_free = (phase_r == fcsr_pkg::PH_IDLE) ||
                        ((phase_r == fcsr_pkg::PH_LF) && out_adv);

  assign tick_cd      = (cd_r != '0) ? cd_r - 1'b1 : cd_r;
  assign tick_expired = expired_r || (cd_r == fcsr_pkg::TICK_BITS'(1));
  assign emit_req     = in_func_r && active_r && tick_expired;
  assign proc_go      = in_valid_r && (!emit_req || emitter_free);
  assign in_stall     = in_valid_r && !proc_go;

  assign is_rst = (chars_r[0] == fcsr_pkg::CH_R) && (chars_r[1] == fcsr_pkg::CH_S) &&
                  (chars_r[2] == fcsr_pkg::CH_T);
  assign is_ok  = (chars_r[0] == fcsr_pkg::CH_O) && (chars_r[1] == fcsr_pkg::CH_K);

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && !in_stall) begin
      in_valid_nxt = 1'b1;
    end else if (proc_go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    first_delay_nxt = first_delay_r;
    resend_nxt      = resend_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcsr_pkg::REG_FIRST_DELAY: first_delay_nxt = cfg_data;
        fcsr_pkg::REG_RESEND:      resend_nxt      = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    chars_nxt      = chars_r;
    pos_nxt        = pos_r;
    active_nxt     = active_r;
    cd_nxt         = cd_r;
    expired_nxt    = expired_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    emit_now       = 1'b0;
    rep_val        = held_valid_r ? held_r : in_sample_r;
    if (proc_go) begin
      if (!in_func_r) begin
        if (!in_frame_r) begin
          if (in_rx_byte_r == fcsr_pkg::CH_START) begin
            in_frame_nxt = 1'b1;
          end
        end else if (in_rx_byte_r == fcsr_pkg::CH_END) begin
          if (is_rst) begin
            active_nxt  = 1'b1;
            cd_nxt      = first_delay_r;
            expired_nxt = 1'b0;
          end else if (is_ok) begin
            held_nxt       = in_sample_r;
            held_valid_nxt = 1'b1;
            active_nxt     = 1'b0;
          end
          pos_nxt      = '0;
          in_frame_nxt = 1'b0;
        end else if (in_rx_byte_r != fcsr_pkg::CH_START) begin
          if (pos_r < fcsr_pkg::POS_W'(fcsr_pkg::STORED_CHARS)) begin
            chars_nxt[pos_r[fcsr_pkg::IDX_W-1:0]] = in_rx_byte_r;
            pos_nxt = pos_r + 1'b1;
          end
        end
      end else begin
        cd_nxt      = tick_cd;
        expired_nxt = tick_expired;
        if (emit_req) begin
          if (!held_valid_r) begin
            held_nxt       = in_sample_r;
            held_valid_nxt = 1'b1;
          end
          emit_now    = 1'b1;
          cd_nxt      = resend_r;
          expired_nxt = 1'b0;
        end
      end
    end
  end

  assign step = fcsr_pkg::digit_step(val_r, pow_idx_r);

  always_comb begin
    phase_nxt       = phase_r;
    pre_idx_nxt     = pre_idx_r;
    pow_idx_nxt     = pow_idx_r;
    val_nxt         = val_r;
    out_valid_nxt   = out_valid_r;
    out_tx_byte_nxt = out_tx_byte_r;
    out_last_nxt    = out_last_r;
    if (out_adv) begin
      out_valid_nxt = 1'b0;
      out_last_nxt  = 1'b0;
      unique case (phase_r)
        fcsr_pkg::PH_IDLE: ;
        fcsr_pkg::PH_PREFIX: begin
          out_valid_nxt   = 1'b1;
          out_tx_byte_nxt = fcsr_pkg::prefix_char(pre_idx_r);
          if (pre_idx_r == fcsr_pkg::PRE_W'(fcsr_pkg::PREFIX_LEN - 1)) begin
            phase_nxt = fcsr_pkg::PH_DIGITS;
          end else begin
            pre_idx_nxt = pre_idx_r + 1'b1;
          end
        end
        fcsr_pkg::PH_DIGITS: begin
          out_valid_nxt   = 1'b1;
          out_tx_byte_nxt = fcsr_pkg::CH_ZERO + 8'(step.digit);
          val_nxt         = step.rest;
          if (pow_idx_r == '0) begin
            phase_nxt = fcsr_pkg::PH_HASH;
          end else begin
            pow_idx_nxt = pow_idx_r - 1'b1;
          end
        end
        fcsr_pkg::PH_HASH: begin
          out_valid_nxt   = 1'b1;
          out_tx_byte_nxt = fcsr_pkg::CH_END;
          phase_nxt       = fcsr_pkg::PH_CR;
        end
        fcsr_pkg::PH_CR: begin
          out_valid_nxt   = 1'b1;
          out_tx_byte_nxt = fcsr_pkg::CH_CR;
          phase_nxt       = fcsr_pkg::PH_LF;
        end
        fcsr_pkg::PH_LF: begin
          out_valid_nxt   = 1'b1;
          out_tx_byte_nxt = fcsr_pkg::CH_LF;
          out_last_nxt    = 1'b1;
          phase_nxt       = fcsr_pkg::PH_IDLE;
        end
        default: phase_nxt = fcsr_pkg::PH_IDLE;
      endcase
    end
    if (emit_now) begin
      phase_nxt   = fcsr_pkg::PH_PREFIX;
      pre_idx_nxt = '0;
      val_nxt     = rep_val;
      pow_idx_nxt = fcsr_pkg::digit_top(rep_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      first_delay_r <= fcsr_pkg::FIRST_DELAY_RESET;
      resend_r      <= fcsr_pkg::RESEND_RESET;
      in_frame_r    <= 1'b0;
      for (int i = 0; i < fcsr_pkg::STORED_CHARS; i++) begin
        chars_r[i] <= 8'h00;
      end
      pos_r         <= '0;
      active_r      <= 1'b0;
      cd_r          <= '0;
      expired_r     <= 1'b0;
      held_r        <= '0;
      held_valid_r  <= 1'b0;
      phase_r       <= fcsr_pkg::PH_IDLE;
      pre_idx_r     <= '0;
      pow_idx_r     <= '0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      in_valid_r    <= in_valid_nxt;
      first_delay_r <= first_delay_nxt;
      resend_r      <= resend_nxt;
      in_frame_r    <= in_frame_nxt;
      chars_r       <= chars_nxt;
      pos_r         <= pos_nxt;
      active_r      <= active_nxt;
      cd_r          <= cd_nxt;
      expired_r     <= expired_nxt;
      held_r        <= held_nxt;
      held_valid_r  <= held_valid_nxt;
      phase_r       <= phase_nxt;
      pre_idx_r     <= pre_idx_nxt;
      pow_idx_r     <= pow_idx_nxt;
      out_valid_r   <= out_valid_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_func_r    <= in_func;
      in_rx_byte_r <= in_rx_byte;
      in_sample_r  <= in_adc_sample;
    end
    val_r         <= val_nxt;
    out_tx_byte_r <= out_tx_byte_nxt;
  end

`ifndef SYNTH
  a_report_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_now |-> (phase_r == fcsr_pkg::PH_IDLE) ||
                 ((phase_r == fcsr_pkg::PH_LF) && out_adv))
    else $error("report started while the sequencer was busy");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_tx_byte_r == fcsr_pkg::CH_LF))
    else $error("final character is not a line feed");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == fcsr_pkg::PH_DIGITS) |->
      (32'(val_r) < fcsr_pkg::pow10(32'(pow_idx_r) + 1)))
    else $error("remaining value too large for the current digit");

  a_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
    expired_r |-> (cd_r == '0))
    else $error("countdown flagged expired while still running");
`endif

endmodule

[verif/tb_framed_command_sample_reporter.sv]
`timescale 1ns / 1ps

module tb_framed_command_sample_reporter;
  import fcsr_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT   = 21;
  localparam int MAX_PRINTED    = 100;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LOW  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HIGH = '1;

  typedef enum logic {KIND_BYTE = 1'b0, KIND_TICK = 1'b1} req_kind_t;

  typedef struct {
    req_kind_t              kind;
    logic [7:0]             rx;
    logic [SAMPLE_BITS-1:0] adc;
    bit                     hold;
  } req_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } tx_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_func = 1'b0;
  logic [7:0]              in_rx_byte = '0;
  logic [SAMPLE_BITS-1:0]  in_adc_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [7:0]              out_tx_byte;
  logic                    out_last;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [TICK_BITS-1:0]    cfg_data = '0;

  req_t     req_q[$];
  tx_char_t tx_expect_q[$];
  bit       hold_next = 1'b0;
  bit       calm = 1'b0;
  int       mismatches = 0;
  int       cfg_writes = 0;
  int       quiet_cycles = 0;

  // Shadow state of the command parser and the report timer.
  logic [TICK_BITS-1:0]   first_delay = FIRST_DELAY_RESET;
  logic [TICK_BITS-1:0]   resend_period = RESEND_RESET;
  bit                     frame_open = 1'b0;
  logic [7:0]             cmd_chars[STORED_CHARS] = '{default: '0};
  int                     cmd_pos = 0;
  bit                     reporting = 1'b0;
  logic [TICK_BITS-1:0]   ticks_left = '0;
  bit                     ticks_done = 1'b0;
  logic [SAMPLE_BITS-1:0] saved_sample = '0;
  bit                     saved_ok = 1'b0;

  framed_command_sample_reporter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_rx_byte    (in_rx_byte),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic void push_tx(input logic [7:0] ch, input logic fin);
    tx_char_t c;
    c.ch  = ch;
    c.fin = fin;
    tx_expect_q.push_back(c);
  endfunction

  task automatic queue_report();
    logic [7:0] digits[$];
    int unsigned v;
    v = saved_sample;
    do begin
      digits.push_front(8'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    push_tx(CH_START, 1'b0);
    push_tx(CH_A, 1'b0);
    push_tx(CH_D, 1'b0);
    push_tx(CH_C, 1'b0);
    push_tx(CH_EQ, 1'b0);
    foreach (digits[i]) push_tx(digits[i], 1'b0);
    push_tx(CH_END, 1'b0);
    push_tx(CH_CR, 1'b0);
    push_tx(CH_LF, 1'b1);
  endtask

  task automatic advance_reporter(input req_kind_t kind, input logic [7:0] rx,
                                  input logic [SAMPLE_BITS-1:0] adc);
    if (kind == KIND_BYTE) begin
      if (!frame_open) begin
        if (rx == CH_START) frame_open = 1'b1;
      end else if (rx == CH_END) begin
        if (cmd_chars[0] == CH_R && cmd_chars[1] == CH_S && cmd_chars[2] == CH_T) begin
          reporting  = 1'b1;
          ticks_left = first_delay;
          ticks_done = 1'b0;
        end else if (cmd_chars[0] == CH_O && cmd_chars[1] == CH_K) begin
          saved_sample = adc;
          saved_ok     = 1'b1;
          reporting    = 1'b0;
        end
        cmd_pos    = 0;
        frame_open = 1'b0;
      end else if (rx != CH_START && cmd_pos < STORED_CHARS) begin
        cmd_chars[cmd_pos] = rx;
        cmd_pos++;
      end
    end else begin
      if (ticks_left != '0) begin
        ticks_left = ticks_left - 1'b1;
        if (ticks_left == '0) ticks_done = 1'b1;
      end
      if (reporting && ticks_done) begin
        if (!saved_ok) begin
          saved_sample = adc;
          saved_ok     = 1'b1;
        end
        queue_report();
        ticks_left = resend_period;
        ticks_done = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin : drive_requests
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        advance_reporter(req_kind_t'(in_func), in_rx_byte, in_adc_sample);
      end
      if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT) &&
          !(req_q[0].hold && tx_expect_q.size() != 0)) begin
        nxt = req_q.pop_front();
        in_valid      <= 1'b1;
        in_func       <= nxt.kind;
        in_rx_byte    <= nxt.rx;
        in_adc_sample <= nxt.adc;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_report_chars
    tx_char_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tx_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected character %h", out_tx_byte));
        end else begin
          want = tx_expect_q.pop_front();
          if (out_tx_byte !== want.ch) begin
            note_mismatch($sformatf("tx_byte %h, expected %h", out_tx_byte, want.ch));
          end
          if (out_last !== want.fin) begin
            note_mismatch($sformatf("last %b, expected %b on %h", out_last, want.fin,
                                    want.ch));
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin : cfg_writer
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIRST_DELAY: first_delay = cfg_data;
        REG_RESEND:      resend_period = cfg_data;
        default: ;
      endcase
      cfg_valid <= 1'b0;
      cfg_writes++;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("framed_command_sample_reporter regression: fail");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] rand_adc();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_BITS'($urandom_range(9));
      3:       return SAMPLE_BITS'($urandom_range(99));
      default: return SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1));
    endcase
  endfunction

  function automatic logic [7:0] rand_cmd_char();
    case ($urandom_range(5))
      0:       return CH_R;
      1:       return CH_S;
      2:       return CH_T;
      3:       return CH_O;
      4:       return CH_K;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_req(input req_kind_t kind, input logic [7:0] rx,
                                   input logic [SAMPLE_BITS-1:0] adc);
    req_t r;
    r.kind = kind;
    r.rx   = rx;
    r.adc  = adc;
    r.hold = hold_next;
    hold_next = 1'b0;
    req_q.push_back(r);
  endfunction

  function automatic void push_tick(input logic [SAMPLE_BITS-1:0] adc);
    push_req(KIND_TICK, 8'($urandom_range(255)), adc);
  endfunction

  function automatic void push_frame(input string body, input logic [SAMPLE_BITS-1:0] adc);
    push_req(KIND_BYTE, CH_START, adc);
    for (int i = 0; i < body.len(); i++) push_req(KIND_BYTE, body[i], adc);
    push_req(KIND_BYTE, CH_END, adc);
  endfunction

  task automatic random_traffic(input int n);
    int  made;
    int  pick;
    int  k;
    bit  held;
    made = 0;
    held = 1'b0;
    while (made < n) begin
      if (!held && made >= n / 2) begin
        hold_next = 1'b1;
        held      = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        k = $urandom_range(1, 3);
        repeat (k) push_tick(rand_adc());
        made += k;
      end else if (pick < 55) begin
        k = $urandom_range(0, 2);
        push_req(KIND_BYTE, CH_START, rand_adc());
        push_req(KIND_BYTE, CH_R, rand_adc());
        push_req(KIND_BYTE, CH_S, rand_adc());
        push_req(KIND_BYTE, CH_T, rand_adc());
        repeat (k) push_req(KIND_BYTE, rand_cmd_char(), rand_adc());
        push_req(KIND_BYTE, CH_END, rand_adc());
        made += 5 + k;
      end else if (pick < 63) begin
        k = $urandom_range(0, 1);
        push_req(KIND_BYTE, CH_START, rand_adc());
        push_req(KIND_BYTE, CH_O, rand_adc());
        push_req(KIND_BYTE, CH_K, rand_adc());
        repeat (k) push_req(KIND_BYTE, rand_cmd_char(), rand_adc());
        push_req(KIND_BYTE, CH_END, rand_adc());
        made += 4 + k;
      end else if (pick < 75) begin
        k = $urandom_range(0, 4);
        push_req(KIND_BYTE, CH_START, rand_adc());
        repeat (k) push_req(KIND_BYTE, rand_cmd_char(), rand_adc());
        push_req(KIND_BYTE, CH_END, rand_adc());
        made += 2 + k;
      end else if (pick < 85) begin
        push_req(KIND_BYTE, 8'($urandom_range(255)), rand_adc());
        made += 1;
      end else begin
        k = $urandom_range(1, 3);
        push_req(KIND_BYTE, CH_START, rand_adc());
        repeat (k) push_req(KIND_BYTE, rand_cmd_char(), rand_adc());
        made += 1 + k;
      end
    end
  endtask

  task automatic settle();
    while (req_q.size() != 0 || in_valid || tx_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [TICK_BITS-1:0] data);
    int target;
    target = cfg_writes + 1;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    while (cfg_writes < target) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_tick('0);
    push_req(KIND_BYTE, 8'hFF, '1);
    push_req(KIND_BYTE, 8'h00, '0);
    push_frame("RST", '1);
    push_tick('1);
    push_frame("OK", '0);
    // An empty frame reuses the characters left over from the previous one.
    push_frame("", SAMPLE_BITS'(123));
    push_frame("R!STX", SAMPLE_BITS'(2048));
    push_tick(SAMPLE_BITS'(7));
    settle();
    random_traffic(60);
    settle();

    write_reg(REG_FIRST_DELAY, TICK_BITS'(1));
    write_reg(REG_RESEND, TICK_BITS'(1));
    write_reg(REG_UNUSED_HIGH, '0);
    calm = 1'b1;
    random_traffic(110);
    settle();
    calm = 1'b0;

    write_reg(REG_FIRST_DELAY, '1);
    write_reg(REG_RESEND, '1);
    write_reg(REG_UNUSED_LOW, TICK_BITS'($urandom_range(65535)));
    random_traffic(40);
    settle();

    write_reg(REG_FIRST_DELAY, TICK_BITS'($urandom_range(1, 4)));
    write_reg(REG_RESEND, TICK_BITS'($urandom_range(1, 6)));
    random_traffic(110);
    settle();

    write_reg(REG_FIRST_DELAY, TICK_BITS'(2));
    write_reg(REG_RESEND, TICK_BITS'(3));
    random_traffic(80);
    settle();

    if (mismatches == 0) begin
      $display("framed_command_sample_reporter regression: pass");
    end else begin
      $display("framed_command_sample_reporter regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fcsr_pkg.sv
rtl/framed_command_sample_reporter.sv
verif/tb_framed_command_sample_reporter.sv
